@@ rtl/quad_delaunay_diagonal_select_defines.svh @@
// Assertion macros shared by the quad diagonal selector
`ifndef QUAD_DELAUNAY_DIAGONAL_SELECT_DEFINES_SVH
`define QUAD_DELAUNAY_DIAGONAL_SELECT_DEFINES_SVH

// Check that the consequent follows the antecedent in the same cycle
`define QDDS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdds: implication check failed");

// Check that a condition never occurs
`define QDDS_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("qdds: forbidden condition seen");

`endif

@@ rtl/qdds_pkg.sv @@
// Shared widths, latencies, types and helpers of the quad diagonal selector
`timescale 1ns / 1ps
package qdds_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int WORK_BITS   = 26;
  localparam int WC_W        = WORK_BITS + 1;
  localparam int DIFF_W      = WC_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int SQ_IN_W     = 2 * WC_W;
  localparam int SQ_OUT_W    = SQ_IN_W / 2;
  localparam int QUO_W       = SQ_OUT_W;
  localparam int DVD_W       = WORK_BITS + SQ_OUT_W;
  localparam int CTR_W       = QUO_W + 1;
  localparam int DST_W       = CTR_W + 1;
  localparam int DSUM_W      = 2 * DST_W;
  localparam int BL_W        = 7;
  localparam int TOL_W       = 12;
  localparam logic [TOL_W-1:0] TOL_FRAC = TOL_W'(2147);
  localparam int TOL_PRE_SH  = 10;
  localparam int TOL_POST_SH = 20;
  localparam int NUM_COORDS  = 12;

  localparam int NORM_LAT    = 4;
  localparam int FRONT_LAT   = 8;
  localparam int SQRT_LAT    = SQ_OUT_W;
  localparam int DIV_LAT     = QUO_W;
  localparam int LANE_LAT    = FRONT_LAT + SQRT_LAT + 1 + DIV_LAT + 5;
  localparam int TOTAL_LAT   = NORM_LAT + LANE_LAT + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WC_W-1:0]        wcoord_t;
  typedef logic [BL_W-1:0]               blen_t;

  typedef struct packed {
    logic outside;
    logic degen;
  } lane_res_t;

  // Bit length of a magnitude (index of the top set bit plus one)
  function automatic blen_t bitlen64(input logic [63:0] m);
    blen_t r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) r = BL_W'(i + 1);
    end
    return r;
  endfunction

  // Shift a magnitude so that bit bl-1 lands on bit WORK_BITS-1
  function automatic logic [WORK_BITS-1:0] renorm_mag(input logic [63:0] m, input blen_t bl);
    logic [63:0] s;
    if (bl > BL_W'(WORK_BITS)) s = m >> (bl - BL_W'(WORK_BITS));
    else s = m << (BL_W'(WORK_BITS) - bl);
    return s[WORK_BITS-1:0];
  endfunction

  // Attach a sign to a working magnitude
  function automatic wcoord_t apply_sign(input logic [WORK_BITS-1:0] m, input logic neg);
    wcoord_t r;
    r = $signed({1'b0, m});
    return neg ? -r : r;
  endfunction

endpackage

@@ rtl/qdds_norm.sv @@
// Block scaling of the twelve input coordinates to the working width
`timescale 1ns / 1ps
module qdds_norm (
  input  logic             clk,
  input  qdds_pkg::coord_t coord_in  [qdds_pkg::NUM_COORDS],
  output qdds_pkg::wcoord_t coord_out [qdds_pkg::NUM_COORDS]
);
  import qdds_pkg::*;

  logic [COORD_WIDTH-1:0] mag1 [NUM_COORDS];
  logic [COORD_WIDTH-1:0] mag2 [NUM_COORDS];
  logic [COORD_WIDTH-1:0] mag3 [NUM_COORDS];
  logic [NUM_COORDS-1:0]  neg1, neg2, neg3;
  logic [COORD_WIDTH-1:0] or2, or_c;
  blen_t                  bl3;

  // Combine magnitudes: the top bit of the OR gives the bit length of the max
  always_comb begin
    or_c = '0;
    for (int i = 0; i < NUM_COORDS; i++) or_c = or_c | mag1[i];
  end

  always_ff @(posedge clk) begin
    // split sign and magnitude
    for (int i = 0; i < NUM_COORDS; i++) begin
      neg1[i] <= coord_in[i][COORD_WIDTH-1];
      mag1[i] <= coord_in[i][COORD_WIDTH-1] ? unsigned'(-coord_in[i])
                                            : unsigned'(coord_in[i]);
    end
    // gather the common magnitude bits
    or2  <= or_c;
    mag2 <= mag1;
    neg2 <= neg1;
    // find the block exponent
    bl3  <= bitlen64(64'(or2));
    mag3 <= mag2;
    neg3 <= neg2;
    // shift every coordinate by the block exponent
    for (int i = 0; i < NUM_COORDS; i++) begin
      coord_out[i] <= apply_sign(renorm_mag(64'(mag3[i]), bl3), neg3[i]);
    end
  end

endmodule

@@ rtl/qdds_sqrt.sv @@
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module qdds_sqrt (
  input  logic                            clk,
  input  logic [qdds_pkg::SQ_IN_W-1:0]    val,
  output logic [qdds_pkg::SQ_OUT_W-1:0]   root
);
  import qdds_pkg::*;

  localparam int RW = SQ_IN_W + 1;

  logic [RW-1:0]       rem_q  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W];
  logic [RW-1:0]       rem_in [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_in [SQ_OUT_W];

  for (genvar j = 0; j < SQ_OUT_W; j++) begin : g_stage
    localparam int K = SQ_OUT_W - 1 - j;
    logic [RW-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in[j]  = RW'(val);
      assign root_in[j] = '0;
    end else begin : g_rest
      assign rem_in[j]  = rem_q[j-1];
      assign root_in[j] = root_q[j-1];
    end

    // trial is (root + 2^K)^2 - root^2
    assign trial = (RW'(root_in[j]) << (K + 1)) + (RW'(1) << (2 * K));

    // settle one root bit
    always_ff @(posedge clk) begin
      if (rem_in[j] >= trial) begin
        rem_q[j]  <= rem_in[j] - trial;
        root_q[j] <= root_in[j] | (SQ_OUT_W'(1) << K);
      end else begin
        rem_q[j]  <= rem_in[j];
        root_q[j] <= root_in[j];
      end
    end
  end

  assign root = root_q[SQ_OUT_W-1];

endmodule

@@ rtl/qdds_div.sv @@
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module qdds_div (
  input  logic                          clk,
  input  logic [qdds_pkg::DVD_W-1:0]    dividend,
  input  logic [qdds_pkg::SQ_OUT_W-1:0] divisor,
  output logic [qdds_pkg::QUO_W-1:0]    quotient
);
  import qdds_pkg::*;

  logic [DVD_W-1:0]    rem_q  [QUO_W];
  logic [SQ_OUT_W-1:0] dsr_q  [QUO_W];
  logic [QUO_W-1:0]    quo_q  [QUO_W];
  logic [DVD_W-1:0]    rem_in [QUO_W];
  logic [SQ_OUT_W-1:0] dsr_in [QUO_W];
  logic [QUO_W-1:0]    quo_in [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic [DVD_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in[j] = dividend;
      assign dsr_in[j] = divisor;
      assign quo_in[j] = '0;
    end else begin : g_rest
      assign rem_in[j] = rem_q[j-1];
      assign dsr_in[j] = dsr_q[j-1];
      assign quo_in[j] = quo_q[j-1];
    end

    assign trial = DVD_W'(dsr_in[j]) << K;

    // subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      dsr_q[j] <= dsr_in[j];
      if (rem_in[j] >= trial) begin
        rem_q[j] <= rem_in[j] - trial;
        quo_q[j] <= quo_in[j] | (QUO_W'(1) << K);
      end else begin
        rem_q[j] <= rem_in[j];
        quo_q[j] <= quo_in[j];
      end
    end
  end

  assign quotient = quo_q[QUO_W-1];

endmodule

@@ rtl/qdds_lane.sv @@
// One circumcircle test lane: point pt against triangle (a, b, c) on the sphere
`timescale 1ns / 1ps
module qdds_lane (
  input  logic                clk,
  input  qdds_pkg::wcoord_t   pt [3],
  input  qdds_pkg::wcoord_t   a  [3],
  input  qdds_pkg::wcoord_t   b  [3],
  input  qdds_pkg::wcoord_t   c  [3],
  output qdds_pkg::lane_res_t res
);
  import qdds_pkg::*;

  typedef struct packed {
    logic [2:0][WORK_BITS-1:0] umag;
    logic [2:0]                uneg;
    logic [2:0][WC_W-1:0]      a;
    logic [2:0][WC_W-1:0]      pt;
    logic                      degen;
  } carry_t;

  // front pipe for the vertex and test point
  wcoord_t a_pipe  [FRONT_LAT][3];
  wcoord_t pt_pipe [FRONT_LAT][3];

  logic signed [DIFF_W-1:0]  s1_d1 [3];
  logic signed [DIFF_W-1:0]  s1_d2 [3];
  logic signed [PROD_W-1:0]  s2_pr [6];
  logic [SQ_IN_W-1:0]        s2_asq [3];
  logic signed [CROSS_W-1:0] s3_n [3];
  logic [SQ_IN_W-1:0]        s3_asum;
  logic [CROSS_W-1:0]        s4_nmag [3];
  logic [2:0]                s4_neg;
  logic [CROSS_W-1:0]        s4_nor;
  logic [SQ_IN_W-1:0]        s4_asum;
  logic [CROSS_W-1:0]        s5_nmag [3];
  logic [2:0]                s5_neg;
  blen_t                     s5_bl;
  logic                      s5_degen;
  logic [SQ_IN_W-1:0]        s5_asum;
  logic [WORK_BITS-1:0]      s6_umag [3];
  logic [2:0]                s6_neg;
  logic                      s6_degen;
  logic [SQ_IN_W-1:0]        s6_asum;
  logic [SQ_IN_W-1:0]        s7_usq [3];
  logic [WORK_BITS-1:0]      s7_umag [3];
  logic [2:0]                s7_neg;
  logic                      s7_degen;
  logic [SQ_IN_W-1:0]        s7_asum;
  logic [SQ_IN_W-1:0]        s8_usum;
  logic [SQ_IN_W-1:0]        s8_asum;
  carry_t                    s8_carry;

  logic [SQ_OUT_W-1:0]       ga, gu;
  carry_t                    dly1 [SQRT_LAT];

  logic [DVD_W-1:0]          m_prod [3];
  logic [SQ_OUT_W-1:0]       m_den;
  carry_t                    m_carry;
  logic [QUO_W-1:0]          quo [3];
  carry_t                    dly2 [DIV_LAT];

  logic signed [DST_W-1:0]   c_dp [3];
  logic signed [DST_W-1:0]   c_da [3];
  logic                      c_degen;
  logic [DSUM_W-1:0]         q_dp [3];
  logic [DSUM_W-1:0]         q_da [3];
  logic                      q_degen;
  logic [DSUM_W-1:0]         t_dp2, t_da2;
  logic                      t_degen;
  logic [DSUM_W-1:0]         g_dp2, g_da2, g_margin;
  logic                      g_degen;
  logic [DSUM_W+TOL_W-1:0]   marg_prod;
  carry_t                    s8_pack;
  carry_t                    c_src;
  logic signed [CTR_W-1:0]   ctr [3];

  // hold vertex and point while the cross product forms
  always_ff @(posedge clk) begin
    a_pipe[0]  <= a;
    pt_pipe[0] <= pt;
    for (int k = 1; k < FRONT_LAT; k++) begin
      a_pipe[k]  <= a_pipe[k-1];
      pt_pipe[k] <= pt_pipe[k-1];
    end
  end

  // edge vectors, products, cross product and |a|^2
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_d1[i] <= DIFF_W'(b[i]) - DIFF_W'(a[i]);
      s1_d2[i] <= DIFF_W'(c[i]) - DIFF_W'(a[i]);
      s2_asq[i] <= unsigned'(SQ_IN_W'(a_pipe[0][i]) * SQ_IN_W'(a_pipe[0][i]));
    end
    s2_pr[0] <= PROD_W'(s1_d1[1]) * PROD_W'(s1_d2[2]);
    s2_pr[1] <= PROD_W'(s1_d1[2]) * PROD_W'(s1_d2[1]);
    s2_pr[2] <= PROD_W'(s1_d1[2]) * PROD_W'(s1_d2[0]);
    s2_pr[3] <= PROD_W'(s1_d1[0]) * PROD_W'(s1_d2[2]);
    s2_pr[4] <= PROD_W'(s1_d1[0]) * PROD_W'(s1_d2[1]);
    s2_pr[5] <= PROD_W'(s1_d1[1]) * PROD_W'(s1_d2[0]);
    s3_n[0]  <= CROSS_W'(s2_pr[0]) - CROSS_W'(s2_pr[1]);
    s3_n[1]  <= CROSS_W'(s2_pr[2]) - CROSS_W'(s2_pr[3]);
    s3_n[2]  <= CROSS_W'(s2_pr[4]) - CROSS_W'(s2_pr[5]);
    s3_asum  <= s2_asq[0] + s2_asq[1] + s2_asq[2];
  end

  // block scale the circumcentre direction
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_neg[i]  <= s3_n[i][CROSS_W-1];
      s4_nmag[i] <= s3_n[i][CROSS_W-1] ? unsigned'(-s3_n[i]) : unsigned'(s3_n[i]);
    end
    s4_asum  <= s3_asum;
    s4_nor   <= (s3_n[0][CROSS_W-1] ? unsigned'(-s3_n[0]) : unsigned'(s3_n[0]))
              | (s3_n[1][CROSS_W-1] ? unsigned'(-s3_n[1]) : unsigned'(s3_n[1]))
              | (s3_n[2][CROSS_W-1] ? unsigned'(-s3_n[2]) : unsigned'(s3_n[2]));
    s5_bl    <= bitlen64(64'(s4_nor));
    s5_degen <= (s4_nor == '0);
    s5_nmag  <= s4_nmag;
    s5_neg   <= s4_neg;
    s5_asum  <= s4_asum;
    for (int i = 0; i < 3; i++) s6_umag[i] <= renorm_mag(64'(s5_nmag[i]), s5_bl);
    s6_neg   <= s5_neg;
    s6_degen <= s5_degen;
    s6_asum  <= s5_asum;
    for (int i = 0; i < 3; i++) begin
      s7_usq[i] <= SQ_IN_W'(s6_umag[i]) * SQ_IN_W'(s6_umag[i]);
    end
    s7_umag  <= s6_umag;
    s7_neg   <= s6_neg;
    s7_degen <= s6_degen;
    s7_asum  <= s6_asum;
    s8_usum  <= s7_usq[0] + s7_usq[1] + s7_usq[2];
    s8_asum  <= s7_asum;
    s8_carry <= s8_pack;
  end

  always_comb begin
    s8_pack = '0;
    for (int i = 0; i < 3; i++) begin
      s8_pack.umag[i] = s7_umag[i];
      s8_pack.a[i]    = a_pipe[FRONT_LAT-2][i];
      s8_pack.pt[i]   = pt_pipe[FRONT_LAT-2][i];
    end
    s8_pack.uneg  = s7_neg;
    s8_pack.degen = s7_degen;
  end

  qdds_sqrt u_sqrt_a (.clk(clk), .val(s8_asum), .root(ga));
  qdds_sqrt u_sqrt_u (.clk(clk), .val(s8_usum), .root(gu));

  // hold the payload across the square roots
  always_ff @(posedge clk) begin
    dly1[0] <= s8_carry;
    for (int k = 1; k < SQRT_LAT; k++) dly1[k] <= dly1[k-1];
  end

  // scale the direction by |a|
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m_prod[i] <= DVD_W'(dly1[SQRT_LAT-1].umag[i]) * DVD_W'(ga);
    end
    m_den   <= (gu == '0) ? SQ_OUT_W'(1) : gu;
    m_carry <= dly1[SQRT_LAT-1];
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    qdds_div u_div (.clk(clk), .dividend(m_prod[i]), .divisor(m_den), .quotient(quo[i]));
  end

  // hold the payload across the dividers
  always_ff @(posedge clk) begin
    dly2[0] <= m_carry;
    for (int k = 1; k < DIV_LAT; k++) dly2[k] <= dly2[k-1];
  end

  assign c_src = dly2[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr[i] = c_src.uneg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
  end

  // chord distances and the tolerance compare
  assign marg_prod = (DSUM_W+TOL_W)'(t_da2 >> TOL_PRE_SH) * (DSUM_W+TOL_W)'(TOL_FRAC);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c_dp[i] <= DST_W'($signed(c_src.pt[i])) - DST_W'(ctr[i]);
      c_da[i] <= DST_W'($signed(c_src.a[i])) - DST_W'(ctr[i]);
      q_dp[i] <= unsigned'(DSUM_W'(c_dp[i]) * DSUM_W'(c_dp[i]));
      q_da[i] <= unsigned'(DSUM_W'(c_da[i]) * DSUM_W'(c_da[i]));
    end
    c_degen  <= c_src.degen;
    q_degen  <= c_degen;
    t_dp2    <= q_dp[0] + q_dp[1] + q_dp[2];
    t_da2    <= q_da[0] + q_da[1] + q_da[2];
    t_degen  <= q_degen;
    g_dp2    <= t_dp2;
    g_da2    <= t_da2;
    g_margin <= DSUM_W'(marg_prod >> TOL_POST_SH);
    g_degen  <= t_degen;
    res.degen   <= g_degen;
    res.outside <= !g_degen &&
                   ({1'b0, g_dp2} > ({1'b0, g_da2} + {1'b0, g_margin}));
  end

endmodule

@@ rtl/quad_delaunay_diagonal_select.sv @@
// Top level of the quad diagonal selector: scaling, two test lanes and the merge
`timescale 1ns / 1ps
// Quad diagonal selector.
// Input channel: drive the twelve coordinates v0_x..v3_z with start high; the
// quad transfers at every rising edge where start is high and busy is low.
// busy stays low, so a new quad may transfer on every cycle.
// Output channel: done is high for exactly one cycle with use_first_split,
// first_degenerate and second_degenerate; the receiver cannot stall, so the
// result transfers in that cycle.
// Pipeline: 4 scaling stages, 68 lane stages and one merge stage lie between
// the transfer edge and the result. The lane depth is mostly taken by the two
// pipelined units: a 27-stage square root and a 27-stage divider.
// Throughput: one quad per cycle; both circumcircle tests run in separate lanes.
// Reset (rst, synchronous) clears the valid pipe, so no result appears for
// quads taken before reset; data registers are not cleared.
module quad_delaunay_diagonal_select (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v0_x,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v0_y,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v0_z,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v1_x,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v1_y,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v1_z,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v2_x,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v2_y,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v2_z,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v3_x,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v3_y,
  input  logic signed [qdds_pkg::COORD_WIDTH-1:0] v3_z,
  output logic                              done,
  output logic                              use_first_split,
  output logic                              first_degenerate,
  output logic                              second_degenerate
);
  import qdds_pkg::*;
`include "quad_delaunay_diagonal_select_defines.svh"

  coord_t    coord_in [NUM_COORDS];
  wcoord_t   w [NUM_COORDS];
  wcoord_t   p0 [3], p1 [3], p2 [3], p3 [3];
  lane_res_t res1, res2;
  logic [TOTAL_LAT-1:0] vld;

  assign busy = 1'b0;

  assign coord_in[0]  = v0_x;
  assign coord_in[1]  = v0_y;
  assign coord_in[2]  = v0_z;
  assign coord_in[3]  = v1_x;
  assign coord_in[4]  = v1_y;
  assign coord_in[5]  = v1_z;
  assign coord_in[6]  = v2_x;
  assign coord_in[7]  = v2_y;
  assign coord_in[8]  = v2_z;
  assign coord_in[9]  = v3_x;
  assign coord_in[10] = v3_y;
  assign coord_in[11] = v3_z;

  qdds_norm u_norm (.clk(clk), .coord_in(coord_in), .coord_out(w));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = w[i];
      p1[i] = w[3 + i];
      p2[i] = w[6 + i];
      p3[i] = w[9 + i];
    end
  end

  // p3 against (p0, p1, p2) and p1 against (p2, p3, p0)
  qdds_lane u_lane1 (.clk(clk), .pt(p3), .a(p0), .b(p1), .c(p2), .res(res1));
  qdds_lane u_lane2 (.clk(clk), .pt(p1), .a(p2), .b(p3), .c(p0), .res(res2));

  // advance the transfer marks alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL_LAT-2:0], start && !busy};
    end
  end

  // merge the two lane verdicts
  always_ff @(posedge clk) begin
    use_first_split   <= res1.outside && res2.outside;
    first_degenerate  <= res1.degen;
    second_degenerate <= res2.degen;
  end

  assign done = vld[TOTAL_LAT-1];

  `QDDS_ASSERT_IMPLY(a_done_follows_start, clk, rst, done, $past(start && !busy, TOTAL_LAT))
  `QDDS_ASSERT_IMPLY(a_degen_blocks_split, clk, rst, done && (first_degenerate || second_degenerate), !use_first_split)
  `QDDS_ASSERT_NEVER(a_quiet_after_reset, clk, rst, $past(rst) && done)

endmodule
